@@ rtl/mcr_pkg.sv @@
package mcr_pkg;

  // Sequencer states. D*: voice delay, RD*: line reads, IA/IF/FI: interpolation,
  // FAC/LO/HI/PH: phase increment, RA/CS/AC: cosine and mix, N*: output scaling; ADDR: line addresses.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_D1,
    ST_D2,
    ST_ADDR,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_IA,
    ST_IF,
    ST_FI,
    ST_FAC,
    ST_LO,
    ST_HI,
    ST_PH,
    ST_RA,
    ST_CS,
    ST_AC,
    ST_N1,
    ST_N2,
    ST_N3,
    ST_N4,
    ST_N5,
    ST_N6
  } state_t;

  localparam int AMP_W = 16;
  localparam int FREQ_W = 24;
  localparam int COS_W = 17;
  localparam int MUL_W = 33;
  localparam int PROD_W = 2 * MUL_W;

  localparam logic [1:0] REG_BASE_DELAY = 2'd0;
  localparam logic [1:0] REG_DETUNE = 2'd1;
  localparam logic [1:0] REG_PHASE_STEP = 2'd2;

  localparam logic [17:0] BASE_DELAY_RST = 18'd0;
  localparam logic [12:0] DETUNE_RST = 13'd655;
  localparam logic [31:0] PHASE_STEP_RST = 32'd97391;

  // ceil(2^22 / 5); exact floor(x / 5) for any x below 2^22.
  localparam int RECIP5 = 838861;
  localparam int RECIP5_SHIFT = 22;

  localparam int OUT_LIMIT = 20480;

  localparam longint unsigned Q30_ONE = 64'd1073741824;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Cosine table entry in Q1.15, built from a Q30 Taylor series by quarter-wave symmetry.
  function automatic logic signed [COS_W-1:0] cos_entry(input int unsigned idx,
                                                        input int unsigned bits);
    longint unsigned t, q, j, x, x2, acc, s, c, r;
    logic neg;
    logic signed [COS_W-1:0] rv;
    t = 64'd1 << bits;
    q = t >> 2;
    if (64'(idx) <= q) begin
      j = 64'(idx);
      neg = 1'b0;
    end else if (64'(idx) <= 2 * q) begin
      j = 2 * q - 64'(idx);
      neg = 1'b1;
    end else if (64'(idx) <= 3 * q) begin
      j = 64'(idx) - 2 * q;
      neg = 1'b1;
    end else begin
      j = t - 64'(idx);
      neg = 1'b0;
    end
    x = (HALF_PI_Q30 * 64'd4 * j) >> bits;
    x2 = (x * x) >> 30;
    acc = Q30_ONE;
    acc = Q30_ONE - ((x2 * acc / 64'd132) >> 30);
    acc = Q30_ONE - ((x2 * acc / 64'd90) >> 30);
    acc = Q30_ONE - ((x2 * acc / 64'd56) >> 30);
    acc = Q30_ONE - ((x2 * acc / 64'd30) >> 30);
    acc = Q30_ONE - ((x2 * acc / 64'd12) >> 30);
    s = (x2 * acc / 64'd2) >> 30;
    c = (s >= Q30_ONE) ? 64'd0 : Q30_ONE - s;
    r = (c + 64'd16384) >> 15;
    rv = $signed({1'b0, r[15:0]});
    return neg ? -rv : rv;
  endfunction

endpackage

@@ rtl/mcr_mul.sv @@
module mcr_mul (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic signed [mcr_pkg::MUL_W-1:0]      a,
  input  logic signed [mcr_pkg::MUL_W-1:0]      b,
  output logic signed [mcr_pkg::PROD_W-1:0]     p
);

  // The product holds until the next issue, so a result can wait on the output side.
  always_ff @(posedge clk) begin
    if (en) begin
      p <= a * b;
    end
  end

endmodule

@@ rtl/mcr_cos_rom.sv @@
module mcr_cos_rom #(
  parameter int TABLE_BITS = 10
) (
  input  logic                                 clk,
  input  logic                                 rd_en,
  input  logic [TABLE_BITS-1:0]                addr,
  output logic signed [mcr_pkg::COS_W-1:0]     data
);

  localparam int ENTRIES = 1 << TABLE_BITS;

  logic signed [mcr_pkg::COS_W-1:0] rom [ENTRIES];

  for (genvar n = 0; n < ENTRIES; n++) begin : g_rom
    assign rom[n] = mcr_pkg::cos_entry(n, TABLE_BITS);
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      data <= rom[addr];
    end
  end

endmodule

@@ rtl/mcr_dline.sv @@
module mcr_dline #(
  parameter int DEPTH = 1024,
  parameter int AW = 10
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [AW-1:0]                         wr_addr,
  input  logic signed [mcr_pkg::AMP_W-1:0]      wr_amp,
  input  logic signed [mcr_pkg::FREQ_W-1:0]     wr_freq,
  input  logic                                  rd_en,
  input  logic [AW-1:0]                         rd_addr,
  output logic signed [mcr_pkg::AMP_W-1:0]      rd_amp,
  output logic signed [mcr_pkg::FREQ_W-1:0]     rd_freq
);

  // Both lines share one pointer, so they are written and read together in two parallel arrays.
  logic [mcr_pkg::AMP_W-1:0]  amp_mem [DEPTH];
  logic [mcr_pkg::FREQ_W-1:0] freq_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      amp_mem[wr_addr] <= wr_amp;
      freq_mem[wr_addr] <= wr_freq;
    end
    if (rd_en) begin
      rd_amp <= amp_mem[rd_addr];
      rd_freq <= freq_mem[rd_addr];
    end
  end

endmodule

@@ rtl/multivoice_chorus_resynth.sv @@
// An accepted input transaction runs the sequencer through every voice and the output
// scaling before out_valid rises. A new input transaction is taken only once the sequencer
// is back in idle, as all voices go through the single shared 33x33 multiplier and the
// single read port of the delay memory.
// Reset (synchronous, active high) clears the sequencer, registers, pointer, fill count and
// voice phases; delay-line entries not yet written read as zero through the fill count.
module multivoice_chorus_resynth #(
  parameter int DELAY_DEPTH = 1024,
  parameter int HALF_VOICES = 2,
  parameter int COS_TABLE_BITS = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [15:0]  amp_level,
  input  logic signed [23:0]  freq_hz,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [15:0]  audio_out,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int NV = 2 * HALF_VOICES + 1;
  localparam int VW = $clog2(NV);
  localparam int AW = $clog2(DELAY_DEPTH);
  localparam int FW = AW + 1;
  localparam int DMAX = (DELAY_DEPTH - 1) * 256;
  localparam int ACC_W = 40 + $clog2(NV);
  localparam int W3 = ACC_W + 3;
  localparam int Y_MAX = NV * (mcr_pkg::OUT_LIMIT + 1);
  localparam int Y_W = $clog2(Y_MAX + 1);
  localparam int RSH = 24;
  localparam int RECIP_NV = (1 << RSH) / NV;
  localparam longint BIAS = longint'(NV) * (64'd1 << 23);
  localparam int MW = mcr_pkg::MUL_W;

  mcr_pkg::state_t state, state_next;

  logic [17:0] base_delay;
  logic [12:0] detune;
  logic [31:0] phase_step;

  logic [AW-1:0] wr_pos, cur_pos;
  logic [FW-1:0] fill;
  logic [VW-1:0] vi;
  logic [3:0]    k_mul;
  logic [16:0]   factor;
  logic [31:0]   phase [NV];

  logic [AW-1:0] addr0, addr1;
  logic [8:0]    w1;
  logic          v0, v1;
  logic signed [15:0] amp0, amp1;
  logic signed [23:0] frq0, frq1;
  logic signed [23:0] a_int;
  logic signed [31:0] f_int;
  logic [31:0]   hi_r, lohi;
  logic signed [ACC_W-1:0] acc;
  logic [ACC_W-1:0] absacc;
  logic          neg_r;
  logic [W3-1:0] m5;
  logic [Y_W-1:0] y, qe;

  logic                      mul_en;
  logic signed [MW-1:0]      mul_a, mul_b;
  logic signed [2*MW-1:0]    mp;
  logic                      rd_en;
  logic [AW-1:0]             rd_addr;
  logic signed [15:0]        rd_amp;
  logic signed [23:0]        rd_freq;
  logic                      rom_en;
  logic signed [mcr_pkg::COS_W-1:0] rom_data;

  logic in_take, cfg_wr;

  // Voice delay decode.
  logic [21:0]   d_raw, dsat;
  logic [AW-1:0] di, age0, age1, addr0_c, addr1_c;
  logic [7:0]    fd;
  logic [AW:0]   wrap_sum;

  // Output scaling.
  logic [W3:0]       ysum;
  logic [W3-RSH:0]   ys;
  logic [Y_W-1:0]    r_c, q_c, q_lim;
  logic signed [15:0] q_out;

  assign in_take = in_valid && (state == mcr_pkg::ST_IDLE);
  assign in_stall = (state != mcr_pkg::ST_IDLE);
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[3:2])
      mcr_pkg::REG_BASE_DELAY: prdata = {14'd0, base_delay};
      mcr_pkg::REG_DETUNE:     prdata = {19'd0, detune};
      mcr_pkg::REG_PHASE_STEP: prdata = phase_step;
      default:                 prdata = 32'd0;
    endcase
  end

  mcr_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mp)
  );

  mcr_dline #(
    .DEPTH (DELAY_DEPTH),
    .AW    (AW)
  ) u_dline (
    .clk     (clk),
    .wr_en   (in_take),
    .wr_addr (wr_pos),
    .wr_amp  (amp_level),
    .wr_freq (freq_hz),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_amp  (rd_amp),
    .rd_freq (rd_freq)
  );

  mcr_cos_rom #(
    .TABLE_BITS (COS_TABLE_BITS)
  ) u_rom (
    .clk   (clk),
    .rd_en (rom_en),
    .addr  (phase[vi][31 -: COS_TABLE_BITS]),
    .data  (rom_data)
  );

  // The delay product base*(5+k)*ceil(2^22/5) sits in the multiplier output.
  always_comb begin
    d_raw = mp[43:22];
    dsat = (d_raw > 22'(DMAX)) ? 22'(DMAX) : d_raw;
    di = dsat[AW+7:8];
    fd = dsat[7:0];
    age0 = (fd == 8'd0) ? di : AW'(di + 1'b1);
    age1 = AW'(age0 - 1'b1);
    wrap_sum = {1'b0, cur_pos} + (AW+1)'(DELAY_DEPTH) - {1'b0, age0};
    addr0_c = (cur_pos >= age0) ? AW'(cur_pos - age0) : wrap_sum[AW-1:0];
    addr1_c = (addr0_c == AW'(DELAY_DEPTH - 1)) ? '0 : AW'(addr0_c + 1'b1);
  end

  always_comb begin
    ysum = (W3+1)'(m5) + (W3+1)'(BIAS);
    ys = ysum[W3:RSH];
    r_c = Y_W'(y - mp[Y_W-1:0]);
    q_c = (r_c >= Y_W'(NV)) ? Y_W'(qe + 1'b1) : qe;
    q_lim = (q_c > Y_W'(mcr_pkg::OUT_LIMIT)) ? Y_W'(mcr_pkg::OUT_LIMIT) : q_c;
    q_out = neg_r ? -$signed(16'(q_lim)) : $signed(16'(q_lim));
  end

  always_comb begin
    state_next = state;
    mul_en = 1'b0;
    mul_a = '0;
    mul_b = '0;
    rd_en = 1'b0;
    rd_addr = addr0;
    rom_en = 1'b0;
    unique case (state)
      mcr_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = mcr_pkg::ST_D1;
        end
      end
      mcr_pkg::ST_D1: begin
        mul_en = 1'b1;
        mul_a = MW'(base_delay);
        mul_b = MW'(k_mul);
        state_next = mcr_pkg::ST_D2;
      end
      mcr_pkg::ST_D2: begin
        mul_en = 1'b1;
        mul_a = MW'(mp[mcr_pkg::RECIP5_SHIFT-1:0]);
        mul_b = MW'(mcr_pkg::RECIP5);
        state_next = mcr_pkg::ST_ADDR;
      end
      mcr_pkg::ST_ADDR: state_next = mcr_pkg::ST_RD0;
      mcr_pkg::ST_RD0: begin
        rd_en = 1'b1;
        rd_addr = addr0;
        state_next = mcr_pkg::ST_RD1;
      end
      mcr_pkg::ST_RD1: begin
        rd_en = 1'b1;
        rd_addr = addr1;
        state_next = mcr_pkg::ST_RD2;
      end
      mcr_pkg::ST_RD2: state_next = mcr_pkg::ST_IA;
      mcr_pkg::ST_IA: begin
        mul_en = 1'b1;
        mul_a = MW'(17'(amp1) - 17'(amp0));
        mul_b = MW'(w1);
        state_next = mcr_pkg::ST_IF;
      end
      mcr_pkg::ST_IF: begin
        mul_en = 1'b1;
        mul_a = MW'(25'(frq1) - 25'(frq0));
        mul_b = MW'(w1);
        state_next = mcr_pkg::ST_FI;
      end
      mcr_pkg::ST_FI: state_next = mcr_pkg::ST_FAC;
      mcr_pkg::ST_FAC: begin
        mul_en = 1'b1;
        mul_a = MW'(f_int);
        mul_b = MW'(factor);
        state_next = mcr_pkg::ST_LO;
      end
      mcr_pkg::ST_LO: begin
        mul_en = 1'b1;
        mul_a = MW'(mp[31:0]);
        mul_b = MW'(phase_step);
        state_next = mcr_pkg::ST_HI;
      end
      mcr_pkg::ST_HI: begin
        mul_en = 1'b1;
        mul_a = MW'(hi_r);
        mul_b = MW'(phase_step);
        state_next = mcr_pkg::ST_PH;
      end
      mcr_pkg::ST_PH: state_next = mcr_pkg::ST_RA;
      mcr_pkg::ST_RA: begin
        rom_en = 1'b1;
        state_next = mcr_pkg::ST_CS;
      end
      mcr_pkg::ST_CS: begin
        mul_en = 1'b1;
        mul_a = MW'(a_int);
        mul_b = MW'(rom_data);
        state_next = mcr_pkg::ST_AC;
      end
      mcr_pkg::ST_AC: begin
        state_next = (vi == VW'(NV - 1)) ? mcr_pkg::ST_N1 : mcr_pkg::ST_D1;
      end
      mcr_pkg::ST_N1: state_next = mcr_pkg::ST_N2;
      mcr_pkg::ST_N2: state_next = mcr_pkg::ST_N3;
      mcr_pkg::ST_N3: state_next = mcr_pkg::ST_N4;
      mcr_pkg::ST_N4: begin
        mul_en = 1'b1;
        mul_a = MW'(y);
        mul_b = MW'(RECIP_NV);
        state_next = mcr_pkg::ST_N5;
      end
      mcr_pkg::ST_N5: begin
        mul_en = 1'b1;
        mul_a = MW'(mp[RSH+Y_W-1:RSH]);
        mul_b = MW'(NV);
        state_next = mcr_pkg::ST_N6;
      end
      mcr_pkg::ST_N6: begin
        if (!out_valid || !out_stall) begin
          state_next = mcr_pkg::ST_IDLE;
        end
      end
      default: state_next = mcr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mcr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_delay <= mcr_pkg::BASE_DELAY_RST;
      detune <= mcr_pkg::DETUNE_RST;
      phase_step <= mcr_pkg::PHASE_STEP_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        mcr_pkg::REG_BASE_DELAY: base_delay <= pwdata[17:0];
        mcr_pkg::REG_DETUNE:     detune <= pwdata[12:0];
        mcr_pkg::REG_PHASE_STEP: phase_step <= pwdata;
        default: ;
      endcase
    end
  end

  // Control state: pointer, fill count, voice counter, delay and detune factors, phases and out_valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_pos <= '0;
      cur_pos <= '0;
      fill <= '0;
      vi <= '0;
      k_mul <= '0;
      factor <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < NV; i++) begin
        phase[i] <= '0;
      end
    end else begin
      if (in_take) begin
        cur_pos <= wr_pos;
        wr_pos <= (wr_pos == AW'(DELAY_DEPTH - 1)) ? '0 : AW'(wr_pos + 1'b1);
        if (fill != FW'(DELAY_DEPTH)) begin
          fill <= FW'(fill + 1'b1);
        end
        vi <= '0;
        k_mul <= 4'(5 - HALF_VOICES);
        factor <= 17'(17'd65536 - 17'(HALF_VOICES) * 17'(detune));
      end
      if (state == mcr_pkg::ST_PH) begin
        phase[vi] <= phase[vi] + mp[31:0] + lohi;
      end
      if (state == mcr_pkg::ST_AC && vi != VW'(NV - 1)) begin
        vi <= VW'(vi + 1'b1);
        k_mul <= 4'(k_mul + 1'b1);
        factor <= 17'(factor + 17'(detune));
      end
      if (state == mcr_pkg::ST_N6 && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      acc <= '0;
    end
    unique case (state)
      mcr_pkg::ST_ADDR: begin
        addr0 <= addr0_c;
        addr1 <= addr1_c;
        w1 <= (fd == 8'd0) ? 9'd0 : 9'(9'd256 - 9'(fd));
        v0 <= ({1'b0, age0} < fill);
        v1 <= (age0 != '0) && ({1'b0, age1} < fill);
      end
      mcr_pkg::ST_RD1: begin
        amp0 <= v0 ? rd_amp : '0;
        frq0 <= v0 ? rd_freq : '0;
      end
      mcr_pkg::ST_RD2: begin
        amp1 <= v1 ? rd_amp : '0;
        frq1 <= v1 ? rd_freq : '0;
      end
      mcr_pkg::ST_IF: a_int <= 24'(mp[25:0] + {amp0[15], amp0[15], amp0, 8'd0});
      mcr_pkg::ST_FI: f_int <= 32'(mp[33:0] + {{2{frq0[23]}}, frq0, 8'd0});
      mcr_pkg::ST_LO: hi_r <= mp[63:32];
      mcr_pkg::ST_HI: lohi <= mp[63:32];
      mcr_pkg::ST_AC: acc <= acc + ACC_W'(mp);
      mcr_pkg::ST_N1: begin
        absacc <= acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
        neg_r <= acc[ACC_W-1];
      end
      mcr_pkg::ST_N2: m5 <= {1'b0, absacc, 2'b00} + W3'(absacc);
      mcr_pkg::ST_N3: y <= (ys > (W3-RSH+1)'(Y_MAX)) ? Y_W'(Y_MAX) : Y_W'(ys);
      mcr_pkg::ST_N5: qe <= mp[RSH+Y_W-1:RSH];
      mcr_pkg::ST_N6: begin
        if (!out_valid || !out_stall) begin
          audio_out <= q_out;
        end
      end
      default: ;
    endcase
  end

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (audio_out <= 16'sd20480 && audio_out >= -16'sd20480))
    else $error("audio_out outside the clamp range");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again while an item is in progress");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(DELAY_DEPTH))
    else $error("fill count beyond the line depth");

  a_voice_bound: assert property (@(posedge clk) disable iff (rst)
    (state != mcr_pkg::ST_IDLE) |-> (vi <= VW'(NV - 1)))
    else $error("voice counter out of range");

endmodule
